@@ hw/rtl/timing_wheel_scheduler_defines.svh @@
// ----------------------------------------------------------------------------
// timing wheel scheduler assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TIMING_WHEEL_SCHEDULER_DEFINES_SVH
`define TIMING_WHEEL_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define TWS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timing wheel assertion failed");

// next-cycle implication
`define TWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timing wheel assertion failed");

`endif

@@ hw/rtl/tws_pkg.sv @@
// ----------------------------------------------------------------------------
// tws_pkg
// sizes, codes and controller/datapath interface types of the timing wheel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tws_pkg;

  // slot count and slot depth are powers of two
  localparam int SLOTS      = 64;
  localparam int SLOT_DEPTH = 64;

  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int IDX_W    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int ADDR_W   = SLOT_W + IDX_W;
  localparam int ENTRIES  = 2 ** ADDR_W;
  localparam int CNT_W    = $clog2(SLOT_DEPTH + 1);

  localparam int TIME_W   = 32;
  localparam int HANDLE_W = 32;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 3;

  typedef enum logic [1:0] {
    MODE_REGISTER = 2'd0,
    MODE_CANCEL   = 2'd1,
    MODE_FIRE     = 2'd2,
    MODE_TICK     = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_SWEPT = 3'd1,
    ST_RANGE = 3'd2,
    ST_DEAD  = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_TSTART,
    S_SREAD,
    S_SCHECK,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic tick_start;
    logic scan_take;
    logic scan_next;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic cnt_zero;
    logic scan_end;
    logic entry_live;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/timing_wheel_scheduler.sv @@
// ----------------------------------------------------------------------------
// timing_wheel_scheduler
// one-second timing wheel: register, cancel, fire early and second tick
// ----------------------------------------------------------------------------
//   channel   handshake               payload
//   request   req_valid / req_stall   mode, time_now, delay_seconds, payload,
//                                     id_deadline, id_index
//   response  rsp_valid / rsp_stall   status, out_deadline, out_index,
//                                     out_payload, is_expiry, last
//
// register, cancel and fire each step through accept, count/entry memory
//   read, read-modify-write and result load
// a tick steps through accept, count read, count clear, one read and one check
//   per entry below the slot count, and a final flush
// synchronous reset clears the slot count valid bits, swept second and
//   control; entry memories are left as they are
// a stalled response holds the result register; the sweep and the
//   read-modify-write wait for it, and the request side stays stalled until
//   the current item has loaded its final beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timing_wheel_scheduler_defines.svh"

module timing_wheel_scheduler import tws_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [1:0]          mode,
  input  logic [TIME_W-1:0]   time_now,
  input  logic [TIME_W-1:0]   delay_seconds,
  input  logic [HANDLE_W-1:0] payload,
  input  logic [TIME_W-1:0]   id_deadline,
  input  logic [INDEX_W-1:0]  id_index,
  // response channel
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [TIME_W-1:0]   out_deadline,
  output logic [INDEX_W-1:0]  out_index,
  output logic [HANDLE_W-1:0] out_payload,
  output logic                is_expiry,
  output logic                last
);

  // controller commands and datapath status
  cmd_t cmd;
  sts_t sts;

  // sequencer: one request at a time, sweep walks the slot entry by entry
  tws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // memories, decode and result register
  tws_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .time_now      (time_now),
    .delay_seconds (delay_seconds),
    .payload       (payload),
    .id_deadline   (id_deadline),
    .id_index      (id_index),
    .rsp_stall     (rsp_stall),
    .rsp_valid     (rsp_valid),
    .status        (status),
    .out_deadline  (out_deadline),
    .out_index     (out_index),
    .out_payload   (out_payload),
    .is_expiry     (is_expiry),
    .last          (last)
  );

  // an accepted request keeps the block busy in the following cycle
  `TWS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

  // expiry beats carry ok status and no deadline
  `TWS_ASSERT_IMP(a_expiry_fields, rsp_valid && is_expiry, status == ST_OK && out_deadline == '0)

  // failure beats carry no id and no handle
  `TWS_ASSERT_IMP(a_failure_zero, rsp_valid && status != ST_OK, out_deadline == '0 && out_payload == '0 && last)

  // the final sweep beat is only loaded with a held entry and a free register
  `TWS_ASSERT_IMP(a_flush_ready, cmd.flush, sts.pend_valid && sts.out_free)

endmodule

@@ hw/rtl/tws_ctrl.sv @@
// ----------------------------------------------------------------------------
// tws_ctrl
// sequencer for lookup, read-modify-write and slot sweep
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tws_ctrl import tws_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  output logic   req_stall,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = sts.is_tick ? S_TSTART : S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      S_TSTART: begin
        state_next = sts.cnt_zero ? S_FLUSH : S_SREAD;
      end
      S_SREAD: begin
        state_next = S_SCHECK;
      end
      S_SCHECK: begin
        if (!sts.entry_live || !sts.pend_valid || sts.out_free) begin
          state_next = sts.scan_end ? S_FLUSH : S_SREAD;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid || sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      S_EXEC: begin
        cmd.exec = sts.out_free;
      end
      S_TSTART: begin
        cmd.tick_start = 1'b1;
      end
      S_SCHECK: begin
        if (!sts.entry_live) begin
          cmd.scan_next = 1'b1;
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.scan_take = 1'b1;
        end
      end
      S_FLUSH: begin
        cmd.flush = sts.pend_valid && sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/tws_datapath.sv @@
// ----------------------------------------------------------------------------
// tws_datapath
// item registers, slot count and entry memories, sweep pending stage, result
// register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tws_datapath import tws_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [1:0]          mode,
  input  logic [TIME_W-1:0]   time_now,
  input  logic [TIME_W-1:0]   delay_seconds,
  input  logic [HANDLE_W-1:0] payload,
  input  logic [TIME_W-1:0]   id_deadline,
  input  logic [INDEX_W-1:0]  id_index,
  input  logic                rsp_stall,
  output logic                rsp_valid,
  output logic [STATUS_W-1:0] status,
  output logic [TIME_W-1:0]   out_deadline,
  output logic [INDEX_W-1:0]  out_index,
  output logic [HANDLE_W-1:0] out_payload,
  output logic                is_expiry,
  output logic                last
);

  // item registers
  mode_t                it_mode;
  logic [TIME_W-1:0]    it_now;
  logic [TIME_W-1:0]    it_dl;
  logic [HANDLE_W-1:0]  it_payload;
  logic [TIME_W-1:0]    it_id_dl;
  logic [INDEX_W-1:0]   it_id_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_mode    <= mode_t'(mode);
      it_now     <= time_now;
      it_dl      <= time_now + delay_seconds;
      it_payload <= payload;
      it_id_dl   <= id_deadline;
      it_id_idx  <= id_index;
    end
  end

  logic [SLOT_W-1:0] slot_reg, slot_id, slot_now, cslot;
  assign slot_reg = it_dl[SLOT_W-1:0];
  assign slot_id  = it_id_dl[SLOT_W-1:0];
  assign slot_now = it_now[SLOT_W-1:0];

  always_comb begin
    case (it_mode)
      MODE_REGISTER:          cslot = slot_reg;
      MODE_CANCEL, MODE_FIRE: cslot = slot_id;
      default:                cslot = slot_now;
    endcase
  end

  // slot counts with per-slot valid bits cleared at reset
  logic [CNT_W-1:0] cnt_mem [SLOTS];
  logic [SLOTS-1:0] cnt_vld;
  logic [CNT_W-1:0] rd_cnt;
  logic             rd_cvld;
  logic [CNT_W-1:0] count;
  logic             cnt_we;
  logic [CNT_W-1:0] cnt_wdata;

  always_ff @(posedge clk) begin
    rd_cnt <= cnt_mem[cslot];
    if (cnt_we) cnt_mem[cslot] <= cnt_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
      rd_cvld <= 1'b0;
    end else begin
      rd_cvld <= cnt_vld[cslot];
      if (cnt_we) cnt_vld[cslot] <= 1'b1;
    end
  end

  assign count = rd_cvld ? rd_cnt : '0;

  // entry memories
  logic [CNT_W-1:0]    scan_idx;
  logic [CNT_W-1:0]    tcnt;
  logic                live_mem   [ENTRIES];
  logic [HANDLE_W-1:0] handle_mem [ENTRIES];
  logic [ADDR_W-1:0]   ra, wa;
  logic                rd_live;
  logic [HANDLE_W-1:0] rd_handle;
  logic                live_we, live_wd, handle_we;

  assign ra = (it_mode == MODE_TICK) ? {slot_now, scan_idx[IDX_W-1:0]}
                                     : {slot_id, it_id_idx[IDX_W-1:0]};
  assign wa = (it_mode == MODE_REGISTER) ? {slot_reg, count[IDX_W-1:0]} : ra;

  always_ff @(posedge clk) begin
    rd_live   <= live_mem[ra];
    rd_handle <= handle_mem[ra];
    if (live_we)   live_mem[wa]   <= live_wd;
    if (handle_we) handle_mem[wa] <= it_payload;
  end

  // swept second and sweep pending stage
  logic [TIME_W-1:0]   swept;
  logic                pend_valid;
  logic [INDEX_W-1:0]  pend_idx;
  logic [HANDLE_W-1:0] pend_handle;

  always_ff @(posedge clk) begin
    if (rst) begin
      swept      <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.tick_start) begin
        swept      <= it_now;
        pend_valid <= 1'b0;
      end else if (cmd.scan_take) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      tcnt     <= count;
      scan_idx <= '0;
    end else if (cmd.scan_take || cmd.scan_next) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.scan_take) begin
      pend_idx    <= INDEX_W'(scan_idx);
      pend_handle <= rd_handle;
    end
  end

  // result decode
  logic                full, swept_hit, range_hit;
  logic                out_free, out_load;
  status_t             res_status;
  logic [TIME_W-1:0]   res_dl;
  logic [INDEX_W-1:0]  res_idx;
  logic [HANDLE_W-1:0] res_pay;
  logic                res_exp, res_last;

  assign full      = count >= CNT_W'(SLOT_DEPTH);
  assign swept_hit = it_id_dl <= swept;
  assign range_hit = 32'(it_id_idx) >= 32'(count);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign out_load  = cmd.exec || (cmd.scan_take && pend_valid) || cmd.flush;

  always_comb begin
    res_status = ST_OK;
    res_dl     = '0;
    res_idx    = '0;
    res_pay    = '0;
    res_exp    = 1'b0;
    res_last   = 1'b1;
    live_we    = 1'b0;
    live_wd    = 1'b0;
    handle_we  = 1'b0;
    cnt_we     = 1'b0;
    cnt_wdata  = '0;
    if (cmd.exec) begin
      if (it_mode == MODE_REGISTER) begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_dl    = it_dl;
          res_idx   = INDEX_W'(count);
          live_we   = 1'b1;
          live_wd   = 1'b1;
          handle_we = 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = count + 1'b1;
        end
      end else if (swept_hit) begin
        res_status = ST_SWEPT;
      end else if (range_hit) begin
        res_status = ST_RANGE;
      end else if (!rd_live) begin
        res_status = ST_DEAD;
      end else begin
        res_dl  = it_id_dl;
        res_idx = it_id_idx;
        res_pay = (it_mode == MODE_FIRE) ? rd_handle : '0;
        live_we = 1'b1;
      end
    end else begin
      // sweep: emit the held entry, marked final only at flush
      res_idx  = pend_idx;
      res_pay  = pend_handle;
      res_exp  = 1'b1;
      res_last = cmd.flush;
      if (cmd.tick_start) begin
        cnt_we = 1'b1;
      end
      if (cmd.scan_take) begin
        live_we = 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= res_status;
      out_deadline <= res_dl;
      out_index    <= res_idx;
      out_payload  <= res_pay;
      is_expiry    <= res_exp;
      last         <= res_last;
    end
  end

  assign sts.is_tick    = it_mode == MODE_TICK;
  assign sts.cnt_zero   = count == '0;
  assign sts.scan_end   = CNT_W'(scan_idx + 1'b1) == tcnt;
  assign sts.entry_live = rd_live;
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = out_free;

endmodule

@@ verif/timing_wheel_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// timing_wheel_scheduler_tb
// drives register, cancel, fire and tick requests through the timing wheel
// and compares every response beat with a cycle-free model of the wheel or a typed row
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timing_wheel_scheduler_tb;
  import tws_pkg::*;

  localparam int RAND_ITEMS  = 320;
  localparam int BURST_AT    = 100;   // random item where a slot gets overfilled
  localparam int PRESS_AT    = 60;    // random item where the long hold-off starts
  localparam int CALM_FROM   = 200;   // stall-free stretch, both sides
  localparam int CALM_TO     = 260;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;   // covers a full slot sweep
  localparam int DRAIN_LIMIT = 100000;
  localparam int MAX_PRINTS  = 50;

  // one request beat, one response beat
  typedef struct {
    mode_t     mode;
    bit [31:0] now;
    bit [31:0] delay;
    bit [31:0] pay;
    bit [31:0] id_dl;
    bit [5:0]  id_idx;
  } wheel_req_t;

  typedef struct {
    status_t   st;
    bit [31:0] dl;
    bit [5:0]  idx;
    bit [31:0] pay;
    bit        expiry;
    bit        lst;
  } wheel_rsp_t;

  typedef struct {
    wheel_req_t req;
    bit         typed;   // response written out in the row itself
    wheel_rsp_t rsp;
  } dir_row_t;

  typedef struct {
    bit [31:0] dl;
    bit [5:0]  idx;
  } timer_id_t;

  // clock, reset and ports; every input known from time zero
  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                req_valid     = 1'b0;
  logic                req_stall;
  logic [1:0]          mode          = '0;
  logic [TIME_W-1:0]   time_now      = '0;
  logic [TIME_W-1:0]   delay_seconds = '0;
  logic [HANDLE_W-1:0] payload       = '0;
  logic [TIME_W-1:0]   id_deadline   = '0;
  logic [INDEX_W-1:0]  id_index      = '0;
  logic                rsp_valid;
  logic                rsp_stall     = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [TIME_W-1:0]   out_deadline;
  logic [INDEX_W-1:0]  out_index;
  logic [HANDLE_W-1:0] out_payload;
  logic                is_expiry;
  logic                last;

  // wheel model state: live bits, handles, slot fill counts, last swept second
  bit          wheel_live   [ENTRIES];
  bit [31:0]   wheel_handle [ENTRIES];
  int unsigned wheel_count  [SLOTS];
  bit [31:0]   wheel_swept  = '0;

  wheel_rsp_t step_rsp[$];      // beats caused by the request just taken
  wheel_rsp_t rsp_pending[$];   // beats still owed by the block, oldest first
  timer_id_t  id_pool[$];       // ids handed out by successful registers
  dir_row_t   dir_tab[$];

  int  n_err    = 0;
  int  n_req    = 0;
  int  n_rsp    = 0;
  int  n_status [5];
  int  n_expiry = 0;
  bit  calm     = 1'b0;         // no idling on either side
  bit  hold_pending = 1'b0;     // asks the receiver for its long hold-off

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timing_wheel_scheduler dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .mode          (mode),
    .time_now      (time_now),
    .delay_seconds (delay_seconds),
    .payload       (payload),
    .id_deadline   (id_deadline),
    .id_index      (id_index),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .out_deadline  (out_deadline),
    .out_index     (out_index),
    .out_payload   (out_payload),
    .is_expiry     (is_expiry),
    .last          (last)
  );

  task automatic flag_mismatch(string msg);
    if (n_err < MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, msg);
    n_err++;
  endtask

  function automatic wheel_rsp_t mk_rsp(status_t st, bit [31:0] dl, bit [5:0] idx,
                                        bit [31:0] pay, bit expiry, bit lst);
    wheel_rsp_t b;
    b.st     = st;
    b.dl     = dl;
    b.idx    = idx;
    b.pay    = pay;
    b.expiry = expiry;
    b.lst    = lst;
    return b;
  endfunction

  // append one beat to those caused by the current request
  function automatic void step_beat(wheel_rsp_t b);
    step_rsp.insert(step_rsp.size(), b);
  endfunction

  // advance the wheel model by one request and collect its beats in step_rsp
  function automatic void wheel_step(wheel_req_t r);
    bit [31:0]   dl;
    int unsigned slot;
    int unsigned cnt;
    int unsigned addr;
    step_rsp.delete();
    case (r.mode)
      MODE_REGISTER: begin
        dl   = r.now + r.delay;   // wraps at 32 bits
        slot = dl % SLOTS;
        cnt  = wheel_count[slot];
        if (cnt >= SLOT_DEPTH) begin
          step_beat(mk_rsp(ST_FULL, 0, 0, 0, 0, 1));
        end else begin
          addr = slot * SLOT_DEPTH + cnt;
          wheel_live[addr]   = 1'b1;
          wheel_handle[addr] = r.pay;
          wheel_count[slot]  = cnt + 1;
          step_beat(mk_rsp(ST_OK, dl, cnt[5:0], 0, 0, 1));
        end
      end
      MODE_CANCEL, MODE_FIRE: begin
        dl   = r.id_dl;
        slot = dl % SLOTS;
        addr = slot * SLOT_DEPTH + r.id_idx;
        // checks in priority order: swept, beyond count, already retired
        if (dl <= wheel_swept) begin
          step_beat(mk_rsp(ST_SWEPT, 0, 0, 0, 0, 1));
        end else if (r.id_idx >= wheel_count[slot]) begin
          step_beat(mk_rsp(ST_RANGE, 0, 0, 0, 0, 1));
        end else if (!wheel_live[addr]) begin
          step_beat(mk_rsp(ST_DEAD, 0, 0, 0, 0, 1));
        end else begin
          // a stale id aliasing a later entry of the slot retires that entry
          wheel_live[addr] = 1'b0;
          step_beat(mk_rsp(ST_OK, dl, r.id_idx,
                           (r.mode == MODE_FIRE) ? wheel_handle[addr] : 32'd0,
                           0, 1));
        end
      end
      default: begin
        // tick: sweep the slot of this second, whatever each entry's deadline
        slot        = r.now % SLOTS;
        wheel_swept = r.now;
        for (cnt = 0; cnt < wheel_count[slot]; cnt++) begin
          addr = slot * SLOT_DEPTH + cnt;
          if (wheel_live[addr]) begin
            step_beat(mk_rsp(ST_OK, 0, cnt[5:0], wheel_handle[addr], 1, 0));
            wheel_live[addr] = 1'b0;
          end
        end
        wheel_count[slot] = 0;
        if (step_rsp.size() > 0) step_rsp[step_rsp.size() - 1].lst = 1'b1;
      end
    endcase
  endfunction

  function automatic void add_row(mode_t m, bit [31:0] now, bit [31:0] delay,
                                  bit [31:0] pay, bit [31:0] id_dl, bit [5:0] id_idx,
                                  bit typed, status_t st, bit [31:0] odl,
                                  bit [5:0] oidx, bit [31:0] opay);
    dir_row_t row;
    row.req.mode   = m;
    row.req.now    = now;
    row.req.delay  = delay;
    row.req.pay    = pay;
    row.req.id_dl  = id_dl;
    row.req.id_idx = id_idx;
    row.typed      = typed;
    row.rsp        = mk_rsp(st, odl, oidx, opay, 0, 1);
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  // offer one request beat; entered and left at a falling edge
  task automatic send_req(wheel_req_t r, bit typed, wheel_rsp_t want);
    // random idle cycles, with junk on the payload while valid is low
    while (!calm && $urandom_range(0, 99) < 17) begin
      req_valid     <= 1'b0;
      mode          <= 2'($urandom);
      time_now      <= $urandom;
      delay_seconds <= $urandom;
      payload       <= $urandom;
      id_deadline   <= $urandom;
      id_index      <= 6'($urandom);
      @(negedge clk);
    end
    req_valid     <= 1'b1;
    mode          <= r.mode;
    time_now      <= r.now;
    delay_seconds <= r.delay;
    payload       <= r.pay;
    id_deadline   <= r.id_dl;
    id_index      <= r.id_idx;
    // the beat goes across at the first rising edge without stall
    @(posedge clk);
    while (req_stall) @(posedge clk);
    wheel_step(r);
    if (typed) begin
      rsp_pending.insert(rsp_pending.size(), want);
    end else begin
      foreach (step_rsp[k]) rsp_pending.insert(rsp_pending.size(), step_rsp[k]);
    end
    if (r.mode == MODE_REGISTER && step_rsp[0].st == ST_OK) begin
      id_pool.insert(id_pool.size(), '{step_rsp[0].dl, step_rsp[0].idx});
      if (id_pool.size() > 256) void'(id_pool.pop_front());
    end
    n_req++;
    @(negedge clk);
  endtask

  // response checker: each accepted beat against the oldest owed beat
  always @(posedge clk) begin : rsp_check
    wheel_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_rsp++;
      if (status <= ST_FULL) n_status[status]++;
      if (is_expiry) n_expiry++;
      if (rsp_pending.size() == 0) begin
        flag_mismatch($sformatf("beat with nothing owed: status %0d index %0d",
                                status, out_index));
      end else begin
        want = rsp_pending.pop_front();
        if (status !== want.st)
          flag_mismatch($sformatf("status %0d, want %0d", status, want.st));
        if (out_deadline !== want.dl)
          flag_mismatch($sformatf("out_deadline %h, want %h", out_deadline, want.dl));
        if (out_index !== want.idx)
          flag_mismatch($sformatf("out_index %0d, want %0d", out_index, want.idx));
        if (out_payload !== want.pay)
          flag_mismatch($sformatf("out_payload %h, want %h", out_payload, want.pay));
        if (is_expiry !== want.expiry)
          flag_mismatch($sformatf("is_expiry %b, want %b", is_expiry, want.expiry));
        if (last !== want.lst)
          flag_mismatch($sformatf("last %b, want %b", last, want.lst));
      end
    end
  end

  // receiver: random stalls, one long hold-off on request, none while calm
  initial begin : rsp_side
    int k;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_stall   <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
      end else begin
        rsp_stall <= !calm && ($urandom_range(0, 99) < 17);
      end
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout: responses stopped coming");
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    wheel_req_t r;
    wheel_rsp_t none;
    timer_id_t  tid;
    bit [31:0]  sec;
    int         n_rand;
    int         roll;
    int         w;

    none = mk_rsp(ST_OK, 0, 0, 0, 0, 0);

    // directed table:   mode   now  delay  payload  id_dl  id_idx
    //                   typed  status  deadline  index  payload
    add_row(MODE_CANCEL,   0, 0, 0, 0, 0,
            1, ST_SWEPT, 0, 0, 0);                       // deadline not past swept zero
    add_row(MODE_FIRE,     0, 0, 0, 5, 0,
            1, ST_RANGE, 0, 0, 0);                       // empty slot
    add_row(MODE_TICK,     0, 0, 0, 0, 0,
            0, ST_OK, 0, 0, 0);                          // tick with nothing to emit
    add_row(MODE_REGISTER, 0, 5, 32'hFFFF_FFFF, 0, 0,
            1, ST_OK, 5, 0, 0);
    add_row(MODE_REGISTER, 0, 5, 0, 0, 0,
            1, ST_OK, 5, 1, 0);
    add_row(MODE_REGISTER, 32'hFFFF_FFFF, 6, 32'hC3C3_C3C3, 0, 0,
            1, ST_OK, 5, 2, 0);                          // deadline wraps to 5
    add_row(MODE_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 0, 0,
            1, ST_OK, 32'hFFFF_FFFE, 0, 0);
    add_row(MODE_FIRE,     0, 0, 0, 5, 0,
            1, ST_OK, 5, 0, 32'hFFFF_FFFF);
    add_row(MODE_FIRE,     0, 0, 0, 5, 0,
            1, ST_DEAD, 0, 0, 0);                        // already retired
    add_row(MODE_CANCEL,   0, 0, 0, 5, 1,
            1, ST_OK, 5, 1, 0);
    add_row(MODE_CANCEL,   0, 0, 0, 69, 2,
            0, ST_OK, 0, 0, 0);                          // stale id aliasing slot 5
    add_row(MODE_REGISTER, 4, 1, 32'hA5A5_A5A5, 0, 0,
            0, ST_OK, 0, 0, 0);
    add_row(MODE_REGISTER, 4, 65, 32'h5A5A_5A5A, 0, 0,
            0, ST_OK, 0, 0, 0);                          // next lap, same slot
    add_row(MODE_FIRE,     0, 0, 0, 5, 63,
            1, ST_RANGE, 0, 0, 0);
    add_row(MODE_TICK,     5, 0, 0, 0, 0,
            0, ST_OK, 0, 0, 0);                          // sweeps both laps
    add_row(MODE_CANCEL,   0, 0, 0, 5, 3,
            1, ST_SWEPT, 0, 0, 0);
    add_row(MODE_CANCEL,   0, 0, 0, 69, 0,
            1, ST_RANGE, 0, 0, 0);                       // slot emptied by the sweep
    add_row(MODE_REGISTER, 32'h8000_0000, 0, 32'hDEAD_BEEF, 0, 0,
            1, ST_OK, 32'h8000_0000, 0, 0);
    add_row(MODE_TICK,     32'h8000_0000, 0, 0, 0, 0,
            0, ST_OK, 0, 0, 0);
    add_row(MODE_FIRE,     0, 0, 0, 32'hFFFF_FFFE, 0,
            0, ST_OK, 0, 0, 0);
    add_row(MODE_TICK,     32'hFFFF_FFFF, 0, 0, 0, 0,
            0, ST_OK, 0, 0, 0);
    add_row(MODE_CANCEL,   0, 0, 0, 32'hFFFF_FFFF, 0,
            1, ST_SWEPT, 0, 0, 0);                       // equal to swept second
    add_row(MODE_REGISTER, 0, 0, 0, 0, 0,
            1, ST_OK, 0, 0, 0);
    add_row(MODE_FIRE,     0, 0, 0, 0, 0,
            1, ST_SWEPT, 0, 0, 0);
    add_row(MODE_TICK,     0, 0, 0, 0, 0,
            0, ST_OK, 0, 0, 0);                          // expires the zero-delay entry

    // reset held from time zero, released at a falling edge
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);

    // random part: the wheel clock walks forward one or two seconds per tick
    sec    = $urandom;
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      calm = (n_rand >= CALM_FROM && n_rand < CALM_TO);
      if (n_rand == PRESS_AT) hold_pending = 1'b1;

      // fields a mode ignores still carry random bits
      r.now    = $urandom;
      r.delay  = $urandom;
      r.pay    = $urandom;
      r.id_dl  = $urandom;
      r.id_idx = 6'($urandom);

      if (n_rand == BURST_AT) begin
        // overfill one slot: the tail beats come back slot full
        for (w = 0; w < SLOT_DEPTH + 2; w++) begin
          r.mode  = MODE_REGISTER;
          r.now   = sec;
          r.delay = 30;
          r.pay   = $urandom;
          send_req(r, 0, none);
          n_rand++;
        end
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          r.mode = MODE_REGISTER;
          r.now  = sec;
          roll   = $urandom_range(0, 99);
          if (roll < 88)      r.delay = $urandom_range(0, 140);
          else if (roll < 95) r.delay = $urandom;
          else                r.delay = 0;
        end else if (roll < 70) begin
          r.mode = $urandom_range(0, 1) ? MODE_CANCEL : MODE_FIRE;
          if (id_pool.size() > 0 && $urandom_range(0, 99) < 80) begin
            // mostly ids that were handed out, sometimes one index off
            tid      = id_pool[$urandom_range(0, id_pool.size() - 1)];
            r.id_dl  = tid.dl;
            r.id_idx = tid.idx;
            if ($urandom_range(0, 9) == 0) r.id_idx = tid.idx + 6'd1;
          end else if ($urandom_range(0, 1)) begin
            r.id_dl = sec + $urandom_range(0, 100);
          end
        end else if (roll < 96) begin
          r.mode = MODE_TICK;
          r.now  = sec;
          sec    = sec + $urandom_range(1, 2);
        end else begin
          // tick at an arbitrary second: sweeps a random slot, moves swept far
          r.mode = MODE_TICK;
        end
        send_req(r, 0, none);
        n_rand++;
      end
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    // drain, then give a full sweep's worth of cycles for stray beats
    for (w = 0; w < DRAIN_LIMIT && rsp_pending.size() != 0; w++) @(posedge clk);
    if (rsp_pending.size() != 0)
      flag_mismatch($sformatf("%0d owed beats never came", rsp_pending.size()));
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d requests, %0d response beats: ok %0d, swept %0d, beyond count %0d,",
             n_req, n_rsp, n_status[ST_OK], n_status[ST_SWEPT], n_status[ST_RANGE]);
    $display("not live %0d, slot full %0d, expiries %0d; %0d mismatches",
             n_status[ST_DEAD], n_status[ST_FULL], n_expiry, n_err);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ timing_wheel_scheduler.f @@
+incdir+hw/rtl
hw/rtl/tws_pkg.sv
hw/rtl/tws_ctrl.sv
hw/rtl/tws_datapath.sv
hw/rtl/timing_wheel_scheduler.sv
verif/timing_wheel_scheduler_tb.sv
